### sv/sb64_pkg.sv
// Shared types, constants and helpers of the strict base64 decoder.
// No dependencies; every other file but sb64_checker refers to it by scoped names.
`default_nettype none

package sb64_pkg;

	// decoded length counter width
	localparam int unsigned LEN_W = 24;
	localparam int unsigned CAP_W = 24;
	localparam int unsigned ADDR_W = 3;

	// register index of output_capacity
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 24'hFF_FFFF;

	// characters with a role of their own
	localparam logic [7:0] CH_PAD = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [5:0] OFS_LOWER = 6'd26;
	localparam logic [5:0] OFS_DIGIT = 6'd52;
	localparam logic [5:0] VAL_PLUS = 6'd62;
	localparam logic [5:0] VAL_SLASH = 6'd63;

	// blob status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_LONG = 2'd2
	} status_t;

	// input kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END = 1'b1;

	// results caused by one input item: up to three bytes or one final status
	typedef struct packed {
		logic [1:0]       cnt;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic             final_res;
		status_t          status;
		logic [LEN_W-1:0] length;
	} sb64_grp_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	// returns {valid, value} of an alphabet character
	function automatic logic [6:0] sextet(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b1, d[5:0]};
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61;
			return {1'b1, d[5:0] + OFS_LOWER};
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[5:0] + OFS_DIGIT};
		end
		if (c == CH_PLUS) return {1'b1, VAL_PLUS};
		if (c == CH_SLASH) return {1'b1, VAL_SLASH};
		return 7'd0;
	endfunction

endpackage

`default_nettype wire

### sv/sb64_decode.sv
// Per-character decode step and blob state (quantum, pad count, length, error).
// Depends on sb64_pkg.
`default_nettype none

module sb64_decode (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         item_valid,
	input  wire                         item_kind,
	input  wire  [7:0]                  item_char,
	input  wire                         commit,
	input  wire  [sb64_pkg::CAP_W-1:0]  capacity,
	output sb64_pkg::sb64_grp_t         grp
);

	logic [23:0]                quantum_q, quantum_d;
	logic [1:0]                 chars_q, chars_d;
	logic [1:0]                 pad_q, pad_d;
	logic [sb64_pkg::LEN_W-1:0] bytes_q, bytes_d;
	sb64_pkg::status_t          err_q, err_d;

	logic [6:0]                 sx;
	logic [5:0]                 digit;
	logic                       take;
	logic [23:0]                v;
	logic [1:0]                 want;
	logic [sb64_pkg::LEN_W:0]   sum;
	sb64_pkg::status_t          st;

	assign sx = sb64_pkg::sextet(item_char);

	// compute next state and the results of the held item
	always_comb begin
		quantum_d = quantum_q;
		chars_d = chars_q;
		pad_d = pad_q;
		bytes_d = bytes_q;
		err_d = err_q;
		grp = '0;
		digit = 6'd0;
		take = 1'b0;
		v = '0;
		want = '0;
		sum = '0;
		st = err_q;
		if (item_valid) begin
			if (item_kind == sb64_pkg::KIND_END) begin
				if (err_q == sb64_pkg::ST_OK && chars_q != 2'd0) st = sb64_pkg::ST_BAD;
				grp.cnt = 2'd1;
				grp.final_res = 1'b1;
				grp.status = st;
				grp.length = (st == sb64_pkg::ST_OK) ? bytes_q : '0;
				quantum_d = '0;
				chars_d = '0;
				pad_d = '0;
				bytes_d = '0;
				err_d = sb64_pkg::ST_OK;
			end else if (err_q == sb64_pkg::ST_OK && !sb64_pkg::is_space(item_char)) begin
				if (item_char == sb64_pkg::CH_PAD) begin
					if (pad_q == 2'd2) begin
						err_d = sb64_pkg::ST_BAD;
					end else begin
						pad_d = pad_q + 2'd1;
						take = 1'b1;
					end
				end else if (pad_q != 2'd0 || !sx[6]) begin
					err_d = sb64_pkg::ST_BAD;
				end else begin
					digit = sx[5:0];
					take = 1'b1;
				end
				if (take) begin
					v = {quantum_q[17:0], digit};
					want = 2'd3 - pad_d;
					sum = {1'b0, bytes_q} + {{(sb64_pkg::LEN_W-1){1'b0}}, want};
					if (chars_q != 2'd3) begin
						quantum_d = v;
						chars_d = chars_q + 2'd1;
					end else begin
						quantum_d = '0;
						chars_d = '0;
						// spare bits of a padded quantum must be zero
						if ((pad_d == 2'd1 && v[7:0] != 8'h00) ||
						    (pad_d == 2'd2 && v[15:0] != 16'h0000)) begin
							err_d = sb64_pkg::ST_BAD;
						end else if (sum > {1'b0, capacity}) begin
							err_d = sb64_pkg::ST_LONG;
						end else begin
							grp.cnt = want;
							grp.b0 = v[23:16];
							grp.b1 = v[15:8];
							grp.b2 = v[7:0];
							bytes_d = sum[sb64_pkg::LEN_W-1:0];
						end
					end
				end
			end
		end
	end

	// advance blob state when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= '0;
			chars_q <= '0;
			pad_q <= '0;
			bytes_q <= '0;
			err_q <= sb64_pkg::ST_OK;
		end else if (commit) begin
			quantum_q <= quantum_d;
			chars_q <= chars_d;
			pad_q <= pad_d;
			bytes_q <= bytes_d;
			err_q <= err_d;
		end
	end

endmodule

`default_nettype wire

### sv/sb64_out_buf.sv
// Result register: holds the results of one item and sends them one per cycle while m_tready is high.
// Depends on sb64_pkg.
`default_nettype none

module sb64_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  wire sb64_pkg::sb64_grp_t grp_in,
	output logic                 free,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [39:0]          m_tdata,
	output logic                 m_tlast
);

	logic [1:0]                 cnt_q;
	logic [7:0]                 b0_q, b1_q, b2_q;
	logic                       final_q;
	sb64_pkg::status_t          status_q;
	logic [sb64_pkg::LEN_W-1:0] len_q;
	logic                       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign pop = m_tvalid && m_tready;
	assign free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);

	assign m_tdata = {6'd0, len_q, status_q, b0_q};
	assign m_tlast = final_q;

	// count of pending results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= grp_in.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// load a new group or shift the next byte to the head
	always_ff @(posedge clk) begin
		if (load) begin
			b0_q <= grp_in.final_res ? 8'h00 : grp_in.b0;
			b1_q <= grp_in.b1;
			b2_q <= grp_in.b2;
			final_q <= grp_in.final_res;
			status_q <= grp_in.status;
			len_q <= grp_in.length;
		end else if (pop) begin
			b0_q <= b1_q;
			b1_q <= b2_q;
		end
	end

endmodule

`default_nettype wire

### sv/strict_base64_decoder_core.sv
// Top level of the strict base64 decoder: input stage, configuration port,
// decode step and result register. Depends on sb64_pkg, sb64_decode, sb64_out_buf.
//
// Usage:
//   Slave channel: s_tuser = kind (1 = end of blob), s_tdata = encoded character.
//   Master channel: one transaction per result. m_tlast marks the end-of-blob
//   status result; m_tdata carries the decoded byte, status and decoded length.
//   APB port: output_capacity at byte address 0; pready is always high.
// Flow: an accepted item sits in the input stage until its results fit in the result
//   register, which then offers them on the master channel. Further bytes of the
//   same quantum follow one per cycle while m_tready is high.
// Throughput: one item per cycle unless an item waits as below. The result register
//   sends one result per cycle while m_tready is high, so a three-byte quantum drains
//   while the next quantum's characters arrive. An item with results (quantum end or
//   end item) that reaches the input stage before the previous group has drained
//   waits; an end item right after a three-byte quantum waits until its last byte is taken.
// Reset: capacity returns to 0xFFFFFF, blob state clears, no result is pending.
// Stall: when m_tready is low the result register holds its group; items without
//   results still pass the input stage, and s_tready falls while the held item has
//   results that the result register cannot take. Nothing is dropped.
`default_nettype none

module strict_base64_decoder_core (
	input  wire                         clk,
	input  wire                         arst_n,
	// slave stream
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire  [7:0]                  s_tdata,   // [7:0] in_char
	input  wire                         s_tuser,   // [0] kind
	// master stream
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [39:0]                 m_tdata,   // [7:0] data byte, [9:8] status,
	                                               // [33:10] decoded_length, rest 0
	output logic                        m_tlast,   // is_final
	// configuration
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [sb64_pkg::ADDR_W-1:0] paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic                       valid_s1;
	logic                       kind_s1;
	logic [7:0]                 char_s1;
	logic [sb64_pkg::CAP_W-1:0] capacity_q;
	sb64_pkg::sb64_grp_t        grp;
	logic                       buf_free;
	logic                       advance;
	logic                       reg_sel;

	assign pready = 1'b1;
	assign reg_sel = paddr[2];
	assign prdata = (reg_sel == sb64_pkg::REG_CAPACITY) ?
		{{(32-sb64_pkg::CAP_W){1'b0}}, capacity_q} : 32'd0;

	// write the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= sb64_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && reg_sel == sb64_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[sb64_pkg::CAP_W-1:0];
		end
	end

	// the held item moves on when its results fit in the result register
	assign advance = valid_s1 && (grp.cnt == 2'd0 || buf_free);
	assign s_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	sb64_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_kind  (kind_s1),
		.item_char  (char_s1),
		.commit     (advance),
		.capacity   (capacity_q),
		.grp        (grp)
	);

	sb64_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && grp.cnt != 2'd0),
		.grp_in   (grp),
		.free     (buf_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### sv/sb64_checker.sv
// Port-level checks of strict_base64_decoder_core, attached by bind.
// Depends on the top level's ports only.
`default_nettype none

module sb64_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast,
	input wire        pready
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// a byte result carries no status or length
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[39:8] == 32'd0)
		else $error("byte result with status or length");

	// a final result has a zero byte and a legal status
	a_final_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0 && m_tdata[9:8] != 2'd3)
		else $error("bad final result fields");

	// an error blob reports length zero
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[9:8] != 2'd0 |-> m_tdata[33:10] == 24'd0)
		else $error("error status with nonzero length");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind strict_base64_decoder_core sb64_checker u_sb64_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.pready   (pready)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for strict_base64_decoder_core: stream driver, result monitor
// and a decode predictor with its own blob state. Depends on sb64_pkg and the core.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN = 80;
	localparam int REG_UNUSED = 1;

	typedef struct {
		logic       kind;
		logic [7:0] ch;
	} enc_item_t;

	typedef struct {
		logic [7:0]                 data;
		logic                       last;
		sb64_pkg::status_t          status;
		logic [sb64_pkg::LEN_W-1:0] len;
	} blob_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;             // [7:0] in_char
	logic s_tuser = sb64_pkg::KIND_CHAR;     // [0] kind
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;          // [7:0] data byte, [9:8] status, [33:10] decoded_length
	logic m_tlast;                 // is_final
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [sb64_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// stimulus and expected results
	enc_item_t encoded_items[$];
	blob_result_t decoded_due[$];
	blob_result_t due_head;

	// predictor state
	logic [sb64_pkg::CAP_W-1:0] capacity = sb64_pkg::CAP_RESET;
	logic [23:0] quad_bits = '0;
	int quad_count = 0;
	int pad_seen = 0;
	logic [sb64_pkg::LEN_W-1:0] byte_count = '0;
	sb64_pkg::status_t blob_err = sb64_pkg::ST_OK;

	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asks = 0;
	int hold_done = 0;
	int hold_left = 0;
	int cycle_count = 0;

	strict_base64_decoder_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch on %s: expected %0h, got %0h", what, exp_v, got_v);
		end
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == sb64_pkg::CH_SPACE || c == sb64_pkg::CH_TAB ||
			c == sb64_pkg::CH_CR || c == sb64_pkg::CH_LF;
	endfunction

	// 6-bit value of an alphabet character, -1 otherwise
	function automatic int sextet_of(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'("A");
		if (c >= "a" && c <= "z") return int'(c) - int'("a") + int'(sb64_pkg::OFS_LOWER);
		if (c >= "0" && c <= "9") return int'(c) - int'("0") + int'(sb64_pkg::OFS_DIGIT);
		if (c == sb64_pkg::CH_PLUS) return int'(sb64_pkg::VAL_PLUS);
		if (c == sb64_pkg::CH_SLASH) return int'(sb64_pkg::VAL_SLASH);
		return -1;
	endfunction

	function automatic logic [7:0] char_of(input int v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		if (v == 62) return sb64_pkg::CH_PLUS;
		return sb64_pkg::CH_SLASH;
	endfunction

	function automatic void clear_blob();
		quad_bits = '0;
		quad_count = 0;
		pad_seen = 0;
		byte_count = '0;
		blob_err = sb64_pkg::ST_OK;
	endfunction

	// advance the decoder state by one accepted item and queue what it yields
	function automatic void decode_item(input enc_item_t it);
		blob_result_t r;
		int val;
		int want;
		logic [23:0] v;
		sb64_pkg::status_t st;
		r.data = 8'h00;
		r.last = 1'b0;
		r.status = sb64_pkg::ST_OK;
		r.len = '0;
		if (it.kind == sb64_pkg::KIND_END) begin
			st = blob_err;
			if (st == sb64_pkg::ST_OK && quad_count != 0) st = sb64_pkg::ST_BAD;
			r.last = 1'b1;
			r.status = st;
			r.len = (st == sb64_pkg::ST_OK) ? byte_count : '0;
			decoded_due.push_back(r);
			clear_blob();
			return;
		end
		if (blob_err != sb64_pkg::ST_OK || is_blank(it.ch)) return;
		if (it.ch == sb64_pkg::CH_PAD) begin
			if (pad_seen >= 2) begin
				blob_err = sb64_pkg::ST_BAD;
				return;
			end
			pad_seen++;
			val = 0;
		end else begin
			val = sextet_of(it.ch);
			if (pad_seen != 0 || val < 0) begin
				blob_err = sb64_pkg::ST_BAD;
				return;
			end
		end
		v = {quad_bits[17:0], val[5:0]};
		if (quad_count < 3) begin
			quad_bits = v;
			quad_count++;
			return;
		end
		quad_bits = '0;
		quad_count = 0;
		// spare bits under the padding must be zero
		if ((pad_seen == 1 && v[7:0] != 8'h00) || (pad_seen == 2 && v[15:0] != 16'h0000)) begin
			blob_err = sb64_pkg::ST_BAD;
			return;
		end
		want = 3 - pad_seen;
		if ({1'b0, byte_count} + {1'b0, want[sb64_pkg::LEN_W-1:0]} > {1'b0, capacity}) begin
			blob_err = sb64_pkg::ST_LONG;
			return;
		end
		for (int k = 0; k < want; k++) begin
			r.data = v[23 - 8 * k -: 8];
			decoded_due.push_back(r);
		end
		byte_count = byte_count + want[sb64_pkg::LEN_W-1:0];
	endfunction

	// feed the slave stream from the item queue, holding an offered transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			decode_item(encoded_items.pop_front());
		end
		if (s_tvalid && !s_tready) begin
			s_tvalid <= 1'b1;
		end else if (encoded_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata <= encoded_items[0].ch;
			s_tuser <= encoded_items[0].kind;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// count down a long receiver hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_done) begin
			hold_left <= HOLD_LEN;
			hold_done <= hold_asks;
		end
	end

	always @(posedge clk) begin
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_due.size() == 0) begin
				note_mismatch("unexpected result", 32'h0, m_tdata[31:0]);
			end else begin
				due_head = decoded_due.pop_front();
				if (m_tdata[7:0] != due_head.data)
					note_mismatch("data byte", 32'(due_head.data), 32'(m_tdata[7:0]));
				if (m_tlast != due_head.last)
					note_mismatch("is_final", 32'(due_head.last), 32'(m_tlast));
				if (m_tdata[9:8] != due_head.status)
					note_mismatch("status", 32'(due_head.status), 32'(m_tdata[9:8]));
				if (m_tdata[33:10] != due_head.len)
					note_mismatch("decoded_length", 32'(due_head.len), 32'(m_tdata[33:10]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic void push_item(input logic kind, input logic [7:0] ch);
		enc_item_t it;
		it.kind = kind;
		it.ch = ch;
		encoded_items.push_back(it);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_item(sb64_pkg::KIND_CHAR, s[i]);
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(3))
			0: return sb64_pkg::CH_SPACE;
			1: return sb64_pkg::CH_TAB;
			2: return sb64_pkg::CH_CR;
			default: return sb64_pkg::CH_LF;
		endcase
	endfunction

	// build one blob, mostly well formed, sometimes broken; returns items queued
	function automatic int queue_blob();
		logic [7:0] chars[$];
		int nquads;
		int pads;
		int flaw;
		int pos;
		int v;
		int n;
		n = 0;
		nquads = $urandom_range(3);
		flaw = ($urandom_range(99) < 35) ? $urandom_range(4) : -1;
		for (int q = 0; q < nquads; q++) begin
			pads = (q == nquads - 1) ? $urandom_range(2) : 0;
			if (flaw == 4 && q == nquads - 1 && pads == 0) pads = 1 + $urandom_range(1);
			for (int i = 0; i < 4; i++) begin
				if (i >= 4 - pads) begin
					chars.push_back(sb64_pkg::CH_PAD);
				end else begin
					v = $urandom_range(63);
					// clear the spare bits unless they are meant to be dirty
					if (pads != 0 && i == 3 - pads && flaw != 4) v = v & ~((1 << (2 * pads)) - 1);
					chars.push_back(char_of(v));
				end
			end
		end
		if (chars.size() != 0) begin
			pos = $urandom_range(chars.size() - 1);
			case (flaw)
				0: chars[pos] = 8'($urandom_range(255));
				1: chars.insert(pos, sb64_pkg::CH_PAD);
				2: chars.delete(pos);
				3: chars.push_back(char_of($urandom_range(63)));
				default: ;
			endcase
		end else if (flaw == 0) begin
			chars.push_back(8'($urandom_range(255)));
		end
		foreach (chars[i]) begin
			if ($urandom_range(99) < 8) begin
				push_item(sb64_pkg::KIND_CHAR, random_blank());
				n++;
			end
			push_item(sb64_pkg::KIND_CHAR, chars[i]);
			n++;
		end
		push_item(sb64_pkg::KIND_END, 8'($urandom_range(255)));
		return n + 1;
	endfunction

	task automatic apb_cycle(input logic wr, input int reg_idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		logic [sb64_pkg::ADDR_W-1:0] byte_addr;
		int addr_full;
		addr_full = reg_idx * 4;
		byte_addr = addr_full[sb64_pkg::ADDR_W-1:0];
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= byte_addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		if (wr && reg_idx == int'(sb64_pkg::REG_CAPACITY)) capacity = wdata[sb64_pkg::CAP_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_capacity();
		logic [31:0] rd;
		apb_cycle(1'b0, int'(sb64_pkg::REG_CAPACITY), 32'h0, rd);
		if (rd[sb64_pkg::CAP_W-1:0] != capacity)
			note_mismatch("output_capacity readback", 32'(capacity), rd);
	endtask

	task automatic set_capacity(input logic [sb64_pkg::CAP_W-1:0] cap);
		logic [31:0] rd;
		apb_cycle(1'b1, int'(sb64_pkg::REG_CAPACITY), {8'($urandom_range(255)), cap}, rd);
		check_capacity();
	endtask

	// pause until every item is taken and every result has come back
	task automatic wait_drained();
		while (encoded_items.size() != 0 || s_tvalid || decoded_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [31:0] rd;
		logic [sb64_pkg::CAP_W-1:0] caps[4];
		int made;
		caps[0] = 24'd5;
		caps[1] = sb64_pkg::CAP_RESET;
		caps[2] = 24'($urandom_range(24));
		caps[3] = 24'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty blob, full alphabet edges with padding and blanks,
		// third pad after bytes were emitted, out-of-alphabet bytes, partial quantum
		@(negedge clk);
		push_item(sb64_pkg::KIND_END, 8'hFF);
		push_text("/+9z\tQQ==\n");
		push_item(sb64_pkg::KIND_END, 8'h00);
		push_text("AA===");
		push_item(sb64_pkg::KIND_END, 8'h5A);
		push_item(sb64_pkg::KIND_CHAR, 8'h00);
		push_item(sb64_pkg::KIND_CHAR, 8'hFF);
		push_item(sb64_pkg::KIND_END, 8'hA5);
		push_text("QUI");
		push_item(sb64_pkg::KIND_END, 8'h01);
		wait_drained();

		// a write to an unused address must leave the capacity alone
		apb_cycle(1'b1, REG_UNUSED, 32'h0, rd);
		check_capacity();
		set_capacity(sb64_pkg::CAP_RESET);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			set_capacity(caps[ph]);
			@(negedge clk);
			made = 0;
			while (made < 22) made += queue_blob();
			// hold the receiver off while the sender keeps offering
			if (ph == 0) hold_asks++;
			wait_drained();
		end

		if (mismatches == 0 && decoded_due.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
